/* design/a32x_pkg.sv */
`timescale 1ns / 1ps
// Package for the Adler-32 plus extra sum block: channel payload types,
// arithmetic constants, mode and register codes. No dependencies.
package a32x_pkg;

    localparam logic [15:0] ADLER_MOD   = 16'd65521;
    localparam logic [16:0] ADLER_MOD2  = 17'd131042;
    localparam logic [31:0] EXTRA_PRIME = 32'hFFFE_FFF9;
    localparam logic [15:0] HALF_MASK   = 16'hFFFF;
    localparam int          CFG_IDX_W   = 1;

    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_HALF = 2'd1,
        MODE_WORD = 2'd2,
        MODE_RSVD = 2'd3
    } mode_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_CHECKSUM = 1'b0,
        CFG_INIT_EXTRA    = 1'b1
    } cfg_reg_e;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] data_word;
        logic        start_req;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] checksum;
        logic [31:0] extra_sum;
        logic        final_res;
    } out_item_t;

    // Classified work entry: bytes aligned to the top, count of bytes minus one
    typedef struct packed {
        logic [31:0] bytes;
        logic [1:0]  remain;
        logic        start_req;
        logic        last;
    } task_t;

    typedef struct packed {
        logic [15:0] low;
        logic [15:0] high;
        logic [31:0] extra;
    } sums_t;

endpackage

/* design/adler32_with_extra_sum.sv */
`timescale 1ns / 1ps
// Adler-32 checksum with an extra 32-bit sum modulo 0xFFFEFFF9.
// Top level: configuration registers, a32x_front and a32x_back. Uses a32x_pkg.
//
// Input channel in_valid/in_ready/in_item carries one, two or four bytes
// per transfer (mode), MSB first; start_req reloads the sums from the
// configured initial values first. Each input transfer yields exactly one
// output transfer on out_valid/out_ready/out_item with the packed checksum,
// the extra sum and the echoed last flag.
// The back end folds one byte per cycle, save when a stalled receiver holds
// back an item's last byte; items of one, two or four bytes fold byte by byte.
// A two-entry queue sits between front and back; the result register lets
// the next item fold while the previous result waits. When the receiver
// stalls, folding stops only at the last byte of the next item.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// index 0 is initial_checksum (reset 1), index 1 is initial_extra (reset 0).
// Reset (rst_n, async, active low) sets the sums to s1=1, s2=0, extra=0
// and empties the queue and the result register.
module adler32_with_extra_sum
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  a32x_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output a32x_pkg::out_item_t                  out_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [a32x_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);
    import a32x_pkg::*;

    logic [31:0] init_checksum_reg;
    logic [31:0] init_extra_reg;
    logic        q_valid;
    logic        q_ready;
    task_t       q_task;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_checksum_reg <= 32'd1;
            init_extra_reg    <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_INIT_CHECKSUM: init_checksum_reg <= cfg_data;
                CFG_INIT_EXTRA:    init_extra_reg    <= cfg_data;
            endcase
        end
    end

    a32x_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_task   (q_task)
    );

    a32x_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_task        (q_task),
        .init_checksum (init_checksum_reg),
        .init_extra    (init_extra_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item)
    );

endmodule

/* design/a32x_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input transfers, decodes mode into an aligned byte
// group with a byte count, and buffers entries in a two-deep queue. Uses a32x_pkg.
module a32x_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  a32x_pkg::in_item_t in_item,
    output logic               q_valid,
    input  logic               q_ready,
    output a32x_pkg::task_t    q_task
);
    import a32x_pkg::*;

    task_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    task_t       cls;
    logic        push;
    logic        pop;

    always_comb
    begin
        cls.start_req = in_item.start_req;
        cls.last      = in_item.last;
        unique case (mode_e'(in_item.mode))
            MODE_BYTE:
            begin
                cls.bytes  = {in_item.data_word[7:0], 24'd0};
                cls.remain = 2'd0;
            end
            MODE_HALF:
            begin
                cls.bytes  = {in_item.data_word[15:0], 16'd0};
                cls.remain = 2'd1;
            end
            MODE_WORD, MODE_RSVD:
            begin
                cls.bytes  = in_item.data_word;
                cls.remain = 2'd3;
            end
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_task   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* design/a32x_back.sv */
`timescale 1ns / 1ps
// Back end: folds one byte per cycle, unless the output stalls it, into the
// Adler and extra sums, result held in an output register. Uses a32x_pkg.
module a32x_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  a32x_pkg::task_t     q_task,
    input  logic [31:0]         init_checksum,
    input  logic [31:0]         init_extra,
    output logic                out_valid,
    input  logic                out_ready,
    output a32x_pkg::out_item_t out_item
);
    import a32x_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    sums_t       sums_reg;
    sums_t       base;
    sums_t       sums_new;
    task_t       cur_reg;
    task_t       src;
    out_item_t   out_reg;
    logic        out_valid_reg;
    logic        running;
    logic        have_work;
    logic        last_byte;
    logic        out_blocked;
    logic        step;
    logic [7:0]  cur_byte;
    logic [16:0] low_sum;
    logic [16:0] high_sum;
    logic [31:0] ext_sum;

    // output decode
    always_comb
    begin
        unique case (state_reg)
            BK_IDLE: running = 1'b0;
            BK_RUN:  running = 1'b1;
        endcase
    end

    assign src         = running ? cur_reg : q_task;
    assign have_work   = running || q_valid;
    assign last_byte   = (src.remain == 2'd0);
    assign out_blocked = out_valid_reg && !out_ready;
    assign step        = have_work && !(last_byte && out_blocked);
    assign q_ready     = !running && !(last_byte && out_blocked);
    assign cur_byte    = src.bytes[31:24];

    always_comb
    begin
        if (!running && q_task.start_req)
        begin
            base.low   = init_checksum[15:0] & HALF_MASK;
            base.high  = init_checksum[31:16] & HALF_MASK;
            base.extra = init_extra;
        end
        else
        begin
            base = sums_reg;
        end
    end

    always_comb
    begin
        low_sum = {1'b0, base.low} + {9'd0, cur_byte};
        if (low_sum >= {1'b0, ADLER_MOD})
        begin
            sums_new.low = 16'(low_sum - {1'b0, ADLER_MOD});
        end
        else
        begin
            sums_new.low = low_sum[15:0];
        end
        high_sum = {1'b0, base.high} + {1'b0, sums_new.low};
        priority if (high_sum >= ADLER_MOD2)
        begin
            sums_new.high = 16'(high_sum - ADLER_MOD2);
        end
        else if (high_sum >= {1'b0, ADLER_MOD})
        begin
            sums_new.high = 16'(high_sum - {1'b0, ADLER_MOD});
        end
        else
        begin
            sums_new.high = high_sum[15:0];
        end
        ext_sum = base.extra + {16'd0, sums_new.high};
        if (ext_sum >= EXTRA_PRIME)
        begin
            sums_new.extra = ext_sum - EXTRA_PRIME;
        end
        else
        begin
            sums_new.extra = ext_sum;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (step && !last_byte)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (step && last_byte)
                begin
                    state_next = BK_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            sums_reg.low   <= 16'd1;
            sums_reg.high  <= 16'd0;
            sums_reg.extra <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (step)
            begin
                sums_reg <= sums_new;
            end
            if (step && last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            cur_reg.bytes     <= {src.bytes[23:0], 8'd0};
            cur_reg.remain    <= src.remain - 2'd1;
            cur_reg.start_req <= 1'b0;
            cur_reg.last      <= src.last;
        end
        if (step && last_byte)
        begin
            out_reg.checksum  <= {sums_new.high, sums_new.low};
            out_reg.extra_sum <= sums_new.extra;
            out_reg.final_res <= src.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

/* tb/a32x_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for adler32_with_extra_sum: snoops the input, output and config
// channels, predicts each result from a private copy of the sums. Uses a32x_pkg.
module a32x_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  a32x_pkg::in_item_t              in_item,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  a32x_pkg::out_item_t             out_item,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [a32x_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              compared
);
    import a32x_pkg::*;

    logic [31:0] cfg_checksum;
    logic [31:0] cfg_extra;
    logic [15:0] sum_lo;
    logic [15:0] sum_hi;
    logic [31:0] acc_extra;
    out_item_t   expected_sums[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic fold_byte(input logic [7:0] b);
        sum_lo = 16'((32'(sum_lo) + 32'(b)) % 32'(ADLER_MOD));
        sum_hi = 16'((32'(sum_hi) + 32'(sum_lo)) % 32'(ADLER_MOD));
        acc_extra = acc_extra + 32'(sum_hi);
        if (acc_extra >= EXTRA_PRIME)
        begin
            acc_extra = acc_extra - EXTRA_PRIME;
        end
    endtask

    task automatic fold_item(input in_item_t it, output out_item_t res);
        if (it.start_req)
        begin
            sum_lo    = cfg_checksum[15:0];
            sum_hi    = cfg_checksum[31:16];
            acc_extra = cfg_extra;
        end
        case (mode_e'(it.mode))
            MODE_BYTE:
            begin
                fold_byte(it.data_word[7:0]);
            end
            MODE_HALF:
            begin
                fold_byte(it.data_word[15:8]);
                fold_byte(it.data_word[7:0]);
            end
            default:
            begin
                // word and reserved modes fold a full word
                fold_byte(it.data_word[31:24]);
                fold_byte(it.data_word[23:16]);
                fold_byte(it.data_word[15:8]);
                fold_byte(it.data_word[7:0]);
            end
        endcase
        res.checksum  = {sum_hi, sum_lo};
        res.extra_sum = acc_extra;
        res.final_res = it.last;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            cfg_checksum = 32'd1;
            cfg_extra    = 32'd0;
            sum_lo       = 16'd1;
            sum_hi       = 16'd0;
            acc_extra    = 32'd0;
            expected_sums.delete();
            mismatches   = 0;
            outstanding  = 0;
            compared     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_e'(cfg_index))
                    CFG_INIT_CHECKSUM: cfg_checksum = cfg_data;
                    CFG_INIT_EXTRA:    cfg_extra    = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got = out_item;
                if (expected_sums.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h", got));
                end
                else
                begin
                    want = expected_sums.pop_front();
                    compared++;
                    if (got.checksum !== want.checksum)
                        report_mismatch($sformatf("checksum got %h exp %h",
                                                  got.checksum, want.checksum));
                    if (got.extra_sum !== want.extra_sum)
                        report_mismatch($sformatf("extra_sum got %h exp %h",
                                                  got.extra_sum, want.extra_sum));
                    if (got.final_res !== want.final_res)
                        report_mismatch($sformatf("final_res got %b exp %b",
                                                  got.final_res, want.final_res));
                end
            end
            if (in_valid && in_ready)
            begin
                fold_item(in_item, want);
                expected_sums.push_back(want);
            end
            outstanding = expected_sums.size();
        end
    end

endmodule

/* tb/tb_adler32_with_extra_sum.sv */
`timescale 1ns / 1ps
// Top of the adler32_with_extra_sum testbench: clock, reset, stimulus and
// verdict. Depends on a32x_pkg, the block and a32x_checker.
module tb_adler32_with_extra_sum;
    import a32x_pkg::*;

    localparam int NUM_SETTINGS = 8;
    localparam int PHASE_ITEMS  = 54;
    localparam int LONG_STALL   = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [31:0]           cfg_data;

    int mismatches;
    int outstanding;
    int compared;
    int items_sent;
    bit idle_on;
    bit stall_req;

    adler32_with_extra_sum dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    a32x_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic in_item_t make_item(input mode_e m, input logic [31:0] d,
                                           input logic s, input logic l);
        in_item_t it;
        it.mode      = m;
        it.data_word = d;
        it.start_req = s;
        it.last      = l;
        return it;
    endfunction

    function automatic in_item_t random_item(input bit force_start);
        in_item_t it;
        it.mode      = 2'($urandom_range(0, 3));
        it.data_word = $urandom;
        it.start_req = force_start || ($urandom_range(0, 15) == 0);
        it.last      = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic push_item(input in_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // waits for the checker to count the last transfer, then for all results
    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_reg_e idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random hold-off per transfer while idle_on, one long hold on request
    initial
    begin : receiver
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_req = 1'b0;
            end
            gap = idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : timeout
        #200000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] cks_set[NUM_SETTINGS];
        logic [31:0] ext_set[NUM_SETTINGS];
        cks_set[0] = 32'h0000_0001;  ext_set[0] = 32'h0000_0000;
        cks_set[1] = 32'h0000_0000;  ext_set[1] = 32'h0000_0000;
        cks_set[2] = 32'hFFFF_FFFF;  ext_set[2] = 32'hFFFF_FFFF;
        cks_set[3] = 32'hFFF0_FFF0;  ext_set[3] = 32'hFFFE_FFF0;
        cks_set[4] = 32'hFFF1_FFF1;  ext_set[4] = EXTRA_PRIME;
        cks_set[5] = $urandom;       ext_set[5] = $urandom;
        cks_set[6] = $urandom;       ext_set[6] = 32'hFFFE_FFF8;
        cks_set[7] = $urandom;       ext_set[7] = $urandom;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idle_on    = 1'b0;
        stall_req  = 1'b0;
        items_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items under the reset values of the registers
        push_item(make_item(MODE_BYTE, 32'h0000_0000, 1'b0, 1'b0));
        push_item(make_item(MODE_BYTE, 32'h0000_00FF, 1'b0, 1'b0));
        push_item(make_item(MODE_BYTE, 32'hFFFF_FF5A, 1'b0, 1'b0));
        push_item(make_item(MODE_HALF, 32'h0000_FFFF, 1'b0, 1'b0));
        push_item(make_item(MODE_HALF, 32'h0000_0000, 1'b0, 1'b0));
        push_item(make_item(MODE_HALF, 32'h1234_5678, 1'b0, 1'b0));
        push_item(make_item(MODE_WORD, 32'hFFFF_FFFF, 1'b0, 1'b0));
        push_item(make_item(MODE_WORD, 32'h0000_0000, 1'b0, 1'b0));
        push_item(make_item(MODE_RSVD, 32'hDEAD_BEEF, 1'b0, 1'b0));
        push_item(make_item(MODE_RSVD, 32'hFFFF_FFFF, 1'b0, 1'b1));
        push_item(make_item(MODE_WORD, 32'h8040_2010, 1'b1, 1'b0));
        push_item(make_item(MODE_BYTE, 32'h0000_0001, 1'b1, 1'b1));
        idle_on = 1'b1;
        repeat (6) push_item(make_item(MODE_WORD, 32'hFFFF_FFFF, 1'b0, 1'b0));
        finish_phase();

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            write_cfg(CFG_INIT_CHECKSUM, cks_set[s]);
            write_cfg(CFG_INIT_EXTRA, ext_set[s]);
            idle_on = (s % 3) != 0;
            if (s == 4)
            begin
                stall_req = 1'b1;
            end
            push_item(random_item(1'b1));
            repeat (PHASE_ITEMS - 1) push_item(random_item(1'b0));
            finish_phase();
        end

        repeat (20) @(posedge clk);
        $display("Ran %0d input transfers over %0d register settings, %0d results compared,",
                 items_sent, NUM_SETTINGS + 1, compared);
        $display("covering all modes, reloads, extreme initial sums and a long output stall.");
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
